FILE: sv/flpd_pkg.sv
// shared types, constants and helpers for the flow pulse leak detector
package flpd_pkg;

    localparam int TIME_WIDTH = 32;

    localparam logic [31:0] MAX32 = 32'hFFFF_FFFF;

    typedef logic [TIME_WIDTH-1:0] tstamp_t;

    localparam tstamp_t ALERT_RESET = TIME_WIDTH'(64'd4294367295);

    typedef enum logic [1:0] {
        FUNC_TICK  = 2'd0,
        FUNC_PULSE = 2'd1,
        FUNC_USAGE = 2'd2,
        FUNC_CLEAR = 2'd3
    } func_t;

    typedef enum logic [2:0] {
        CFG_WINDOW_MS     = 3'd0,
        CFG_PULSE_THRESH  = 3'd1,
        CFG_CLEAR_WINDOWS = 3'd2,
        CFG_COOLDOWN_MS   = 3'd3,
        CFG_LF_MIN_IVL    = 3'd4,
        CFG_LF_MAX_IVL    = 3'd5,
        CFG_LF_HOLD_MS    = 3'd6,
        CFG_CHECK_PERIOD  = 3'd7
    } cfg_index_t;

    typedef struct packed {
        logic [31:0] window_ms;
        logic [15:0] pulse_threshold;
        logic [3:0]  clear_windows;
        logic [31:0] cooldown_ms;
        logic [31:0] low_flow_min_interval;
        logic [31:0] low_flow_max_interval;
        logic [31:0] low_flow_hold_ms;
        logic [15:0] check_period_ms;
    } cfg_t;

    typedef struct packed {
        tstamp_t     clock_ms;
        tstamp_t     last_check_ms;
        tstamp_t     window_start_ms;
        logic [31:0] window_pulses;
        logic        in_use;
        logic        alarm_on;
        logic        status_leak;
        logic [3:0]  clean_count;
        tstamp_t     last_alert_ms;
        tstamp_t     last_pulse_ms;
        logic [31:0] interval_ms;
        logic        trickle_timing;
        tstamp_t     trickle_start_ms;
        logic [31:0] pulses_total;
        logic [31:0] pulses_leaked;
        logic [31:0] leak_duration;
    } state_t;

    // detector state after reset
    localparam state_t STATE_RESET = '{last_alert_ms: ALERT_RESET, default: '0};

    typedef struct packed {
        logic        alarm;
        logic        leak_status;
        logic        notify_clear;
        logic        notify_alert;
        logic [31:0] total_pulse_count;
        logic [31:0] leak_pulse_count;
        logic [31:0] leak_time_ms;
        logic [31:0] pulse_interval_ms;
    } result_t;

    // modular time difference
    function automatic tstamp_t tdiff(input tstamp_t a, input tstamp_t b);
        return a - b;
    endfunction

    // clamp a wide value to 32 bits
    function automatic logic [31:0] sat32(input logic [63:0] v);
        logic [31:0] r;
        r = (v > 64'(MAX32)) ? MAX32 : v[31:0];
        return r;
    endfunction

    // saturating 32-bit accumulate of a possibly wider amount
    function automatic logic [31:0] sat_add32(input logic [31:0] a, input logic [63:0] b);
        logic [32:0] sum;
        logic [31:0] r;
        sum = {1'b0, a} + {1'b0, b[31:0]};
        if (b > 64'(MAX32) || sum[32])
            r = MAX32;
        else
            r = sum[31:0];
        return r;
    endfunction

endpackage

FILE: sv/flpd_step.sv
// next-state and result logic for one event
module flpd_step
    import flpd_pkg::*;
(
    input  state_t      state,
    input  cfg_t        cfg,
    input  logic [1:0]  func,
    input  logic        active,
    output state_t      state_next,
    output result_t     result
);

    state_t  s;
    logic    n_clear;
    logic    n_alert;
    logic    trickle_leak;
    tstamp_t elapsed;
    tstamp_t pulse_gap;

    always_comb
    begin
        s            = state;
        n_clear      = 1'b0;
        n_alert      = 1'b0;
        trickle_leak = 1'b0;
        elapsed      = '0;
        pulse_gap    = '0;

        unique case (func_t'(func))
            FUNC_TICK:
            begin
                s.clock_ms = state.clock_ms + 1'b1;
                if (64'(tdiff(s.clock_ms, s.last_check_ms)) >= 64'(cfg.check_period_ms))
                begin
                    s.last_check_ms = s.clock_ms;
                    // windowed check
                    if (s.in_use)
                    begin
                        if (s.alarm_on)
                        begin
                            s.alarm_on    = 1'b0;
                            s.clean_count = '0;
                            n_clear       = 1'b1;
                        end
                        s.status_leak = 1'b0;
                    end
                    else
                    begin
                        elapsed = tdiff(s.clock_ms, s.window_start_ms);
                        if (64'(elapsed) >= 64'(cfg.window_ms))
                        begin
                            if (s.window_pulses > 32'(cfg.pulse_threshold))
                            begin
                                s.clean_count   = '0;
                                s.pulses_leaked = sat_add32(s.pulses_leaked,
                                                            64'(s.window_pulses));
                                s.leak_duration = sat_add32(s.leak_duration, 64'(elapsed));
                                s.status_leak   = 1'b1;
                                if (!s.alarm_on)
                                begin
                                    s.alarm_on = 1'b1;
                                    if (64'(tdiff(s.clock_ms, s.last_alert_ms)) >
                                        64'(cfg.cooldown_ms))
                                    begin
                                        s.last_alert_ms = s.clock_ms;
                                        n_alert         = 1'b1;
                                    end
                                end
                            end
                            else
                            begin
                                if (s.alarm_on)
                                begin
                                    if (s.clean_count != 4'hF)
                                        s.clean_count = s.clean_count + 1'b1;
                                    if (s.clean_count >= cfg.clear_windows)
                                    begin
                                        s.alarm_on      = 1'b0;
                                        s.clean_count   = '0;
                                        n_clear         = 1'b1;
                                        s.leak_duration = '0;
                                        s.pulses_leaked = '0;
                                    end
                                end
                                s.status_leak = 1'b0;
                            end
                            s.window_start_ms = s.clock_ms;
                            s.window_pulses   = '0;
                        end
                    end
                    // low-flow check
                    if (s.interval_ms != '0 && s.interval_ms >= cfg.low_flow_min_interval &&
                        s.interval_ms <= cfg.low_flow_max_interval)
                    begin
                        if (!s.trickle_timing)
                        begin
                            s.trickle_start_ms = s.clock_ms;
                            s.trickle_timing   = 1'b1;
                        end
                        else if (64'(tdiff(s.clock_ms, s.trickle_start_ms)) >=
                                 64'(cfg.low_flow_hold_ms))
                        begin
                            trickle_leak = 1'b1;
                        end
                    end
                    else
                    begin
                        s.trickle_timing = 1'b0;
                    end
                    if (trickle_leak && !s.alarm_on)
                    begin
                        s.alarm_on = 1'b1;
                        if (64'(tdiff(s.clock_ms, s.last_alert_ms)) > 64'(cfg.cooldown_ms))
                        begin
                            s.last_alert_ms = s.clock_ms;
                            n_alert         = 1'b1;
                        end
                    end
                end
            end
            FUNC_PULSE:
            begin
                pulse_gap      = tdiff(s.clock_ms, s.last_pulse_ms);
                s.pulses_total = sat_add32(s.pulses_total, 64'd1);
                if (!s.in_use)
                    s.window_pulses = sat_add32(s.window_pulses, 64'd1);
                if (pulse_gap != '0)
                    s.interval_ms = sat32(64'(pulse_gap));
                s.last_pulse_ms = s.clock_ms;
            end
            FUNC_USAGE:
            begin
                s.in_use = active;
                if (!active)
                begin
                    s.window_start_ms = s.clock_ms;
                    s.window_pulses   = '0;
                end
            end
            FUNC_CLEAR:
            begin
                s.window_pulses   = '0;
                s.pulses_leaked   = '0;
                s.leak_duration   = '0;
                s.status_leak     = 1'b0;
                s.window_start_ms = s.clock_ms;
            end
            default:
            begin
                s = state;
            end
        endcase

        state_next                = s;
        result.alarm              = s.alarm_on;
        result.leak_status        = s.status_leak;
        result.notify_clear       = n_clear;
        result.notify_alert       = n_alert;
        result.total_pulse_count  = s.pulses_total;
        result.leak_pulse_count   = s.pulses_leaked;
        result.leak_time_ms       = s.leak_duration;
        result.pulse_interval_ms  = s.interval_ms;
    end

endmodule

FILE: sv/flow_pulse_leak_detector_core.sv
// top level of the flow pulse leak detector: request register, step logic, result register
// path: an accepted request is captured in the request register, and its result in the result register
// throughput: one request per cycle while out_ready does not hold the output, set by the single-pass
// step logic between the request register and the result register
// reset: all detector state clears, except the last alert time which starts just over one default
// cooldown before zero; configuration registers return to their defaults
module flow_pulse_leak_detector_core
    import flpd_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [1:0]  func,
    input  logic        active,
    output logic        out_valid,
    input  logic        out_ready,
    output logic        alarm,
    output logic        leak_status,
    output logic        notify_clear,
    output logic        notify_alert,
    output logic [31:0] total_pulse_count,
    output logic [31:0] leak_pulse_count,
    output logic [31:0] leak_time_ms,
    output logic [31:0] pulse_interval_ms,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [31:0] cfg_data
);

    cfg_t        cfg_reg;
    state_t      state_reg;
    state_t      state_next;
    result_t     result_next;
    result_t     result_reg;
    logic        req_valid_reg;
    logic [1:0]  req_func_reg;
    logic        req_active_reg;
    logic        out_valid_reg;
    logic        out_move;
    logic        req_move;

    assign out_move  = !out_valid_reg || out_ready;
    assign req_move  = req_valid_reg && out_move;
    assign in_ready  = !req_valid_reg || out_move;
    assign cfg_ready = 1'b1;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.window_ms             <= 32'd60000;
            cfg_reg.pulse_threshold       <= 16'd3;
            cfg_reg.clear_windows         <= 4'd2;
            cfg_reg.cooldown_ms           <= 32'd600000;
            cfg_reg.low_flow_min_interval <= 32'd341;
            cfg_reg.low_flow_max_interval <= 32'd10204;
            cfg_reg.low_flow_hold_ms      <= 32'd30000;
            cfg_reg.check_period_ms       <= 16'd1000;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index_t'(cfg_index))
                CFG_WINDOW_MS:     cfg_reg.window_ms             <= cfg_data;
                CFG_PULSE_THRESH:  cfg_reg.pulse_threshold       <= cfg_data[15:0];
                CFG_CLEAR_WINDOWS: cfg_reg.clear_windows         <= cfg_data[3:0];
                CFG_COOLDOWN_MS:   cfg_reg.cooldown_ms           <= cfg_data;
                CFG_LF_MIN_IVL:    cfg_reg.low_flow_min_interval <= cfg_data;
                CFG_LF_MAX_IVL:    cfg_reg.low_flow_max_interval <= cfg_data;
                CFG_LF_HOLD_MS:    cfg_reg.low_flow_hold_ms      <= cfg_data;
                CFG_CHECK_PERIOD:  cfg_reg.check_period_ms       <= cfg_data[15:0];
                default:           cfg_reg                       <= cfg_reg;
            endcase
        end
    end

    // request register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            req_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            req_func_reg   <= func;
            req_active_reg <= active;
        end
    end

    flpd_step u_step (
        .state      (state_reg),
        .cfg        (cfg_reg),
        .func       (req_func_reg),
        .active     (req_active_reg),
        .state_next (state_next),
        .result     (result_next)
    );

    // detector state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= STATE_RESET;
        end
        else if (req_move)
        begin
            state_reg <= state_next;
        end
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_move)
        begin
            out_valid_reg <= req_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req_move)
        begin
            result_reg <= result_next;
        end
    end

    assign out_valid         = out_valid_reg;
    assign alarm             = result_reg.alarm;
    assign leak_status       = result_reg.leak_status;
    assign notify_clear      = result_reg.notify_clear;
    assign notify_alert      = result_reg.notify_alert;
    assign total_pulse_count = result_reg.total_pulse_count;
    assign leak_pulse_count  = result_reg.leak_pulse_count;
    assign leak_time_ms      = result_reg.leak_time_ms;
    assign pulse_interval_ms = result_reg.pulse_interval_ms;

endmodule

FILE: dv/tb_top.sv
// testbench for the flow pulse leak detector: directed and random event streams checked against a predictor
module tb_top;
    import flpd_pkg::*;

    typedef struct packed {
        func_t kind;
        logic  act;
    } flow_event_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    logic [1:0]  func = 2'd0;
    logic        active = 1'b0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic        alarm;
    logic        leak_status;
    logic        notify_clear;
    logic        notify_alert;
    logic [31:0] total_pulse_count;
    logic [31:0] leak_pulse_count;
    logic [31:0] leak_time_ms;
    logic [31:0] pulse_interval_ms;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [2:0]  cfg_index = 3'd0;
    logic [31:0] cfg_data = 32'd0;

    flow_event_t event_queue[$];
    result_t     predicted_status[$];
    state_t      det;
    cfg_t        det_cfg;
    int          events_added = 0;
    int          errors = 0;
    int          in_gap = 0;
    bit          in_burst = 1'b0;
    int          out_stall = 0;
    bit          out_burst = 1'b0;

    flow_pulse_leak_detector_core uut (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_ready(in_ready),
        .func(func),
        .active(active),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .alarm(alarm),
        .leak_status(leak_status),
        .notify_clear(notify_clear),
        .notify_alert(notify_alert),
        .total_pulse_count(total_pulse_count),
        .leak_pulse_count(leak_pulse_count),
        .leak_time_ms(leak_time_ms),
        .pulse_interval_ms(pulse_interval_ms),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    always #5 clk = ~clk;

    function automatic logic [31:0] clamp_add(input logic [31:0] a, input logic [31:0] b);
        logic [32:0] sum;
        sum = {1'b0, a} + {1'b0, b};
        return sum[32] ? 32'hFFFF_FFFF : sum[31:0];
    endfunction

    function automatic logic try_alarm();
        logic [31:0] since;
        if (det.alarm_on)
            return 1'b0;
        det.alarm_on = 1'b1;
        since = det.clock_ms - det.last_alert_ms;
        if (since > det_cfg.cooldown_ms)
        begin
            det.last_alert_ms = det.clock_ms;
            return 1'b1;
        end
        return 1'b0;
    endfunction

    function automatic result_t detector_step(input func_t kind, input logic act);
        result_t     r;
        logic [31:0] elapsed;
        logic [31:0] gap_ms;
        logic        trickle_hit;
        r = '0;
        trickle_hit = 1'b0;
        case (kind)
            FUNC_TICK:
            begin
                det.clock_ms = det.clock_ms + 1'b1;
                elapsed = det.clock_ms - det.last_check_ms;
                if (elapsed >= det_cfg.check_period_ms)
                begin
                    det.last_check_ms = det.clock_ms;
                    if (det.in_use)
                    begin
                        if (det.alarm_on)
                        begin
                            det.alarm_on = 1'b0;
                            det.clean_count = 4'd0;
                            r.notify_clear = 1'b1;
                        end
                        det.status_leak = 1'b0;
                    end
                    else
                    begin
                        elapsed = det.clock_ms - det.window_start_ms;
                        if (elapsed >= det_cfg.window_ms)
                        begin
                            if (det.window_pulses > det_cfg.pulse_threshold)
                            begin
                                det.clean_count = 4'd0;
                                det.pulses_leaked = clamp_add(det.pulses_leaked, det.window_pulses);
                                det.leak_duration = clamp_add(det.leak_duration, elapsed);
                                det.status_leak = 1'b1;
                                if (try_alarm())
                                    r.notify_alert = 1'b1;
                            end
                            else
                            begin
                                if (det.alarm_on)
                                begin
                                    if (det.clean_count < 4'd15)
                                        det.clean_count = det.clean_count + 1'b1;
                                    if (det.clean_count >= det_cfg.clear_windows)
                                    begin
                                        det.alarm_on = 1'b0;
                                        det.clean_count = 4'd0;
                                        r.notify_clear = 1'b1;
                                        det.leak_duration = 32'd0;
                                        det.pulses_leaked = 32'd0;
                                    end
                                end
                                det.status_leak = 1'b0;
                            end
                            det.window_start_ms = det.clock_ms;
                            det.window_pulses = 32'd0;
                        end
                    end
                    if (det.interval_ms != 32'd0 &&
                        det.interval_ms >= det_cfg.low_flow_min_interval &&
                        det.interval_ms <= det_cfg.low_flow_max_interval)
                    begin
                        if (!det.trickle_timing)
                        begin
                            det.trickle_start_ms = det.clock_ms;
                            det.trickle_timing = 1'b1;
                        end
                        else
                        begin
                            elapsed = det.clock_ms - det.trickle_start_ms;
                            if (elapsed >= det_cfg.low_flow_hold_ms)
                                trickle_hit = 1'b1;
                        end
                    end
                    else
                        det.trickle_timing = 1'b0;
                    if (trickle_hit && try_alarm())
                        r.notify_alert = 1'b1;
                end
            end
            FUNC_PULSE:
            begin
                gap_ms = det.clock_ms - det.last_pulse_ms;
                det.pulses_total = clamp_add(det.pulses_total, 32'd1);
                if (!det.in_use)
                    det.window_pulses = clamp_add(det.window_pulses, 32'd1);
                if (gap_ms != 32'd0)
                    det.interval_ms = gap_ms;
                det.last_pulse_ms = det.clock_ms;
            end
            FUNC_USAGE:
            begin
                det.in_use = act;
                if (!act)
                begin
                    det.window_start_ms = det.clock_ms;
                    det.window_pulses = 32'd0;
                end
            end
            FUNC_CLEAR:
            begin
                det.window_pulses = 32'd0;
                det.pulses_leaked = 32'd0;
                det.leak_duration = 32'd0;
                det.status_leak = 1'b0;
                det.window_start_ms = det.clock_ms;
            end
        endcase
        r.alarm = det.alarm_on;
        r.leak_status = det.status_leak;
        r.total_pulse_count = det.pulses_total;
        r.leak_pulse_count = det.pulses_leaked;
        r.leak_time_ms = det.leak_duration;
        r.pulse_interval_ms = det.interval_ms;
        return r;
    endfunction

    task automatic check_field(input string field, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got)
        begin
            $display("%0t: %s mismatch: expected %0d, actual %0d", $time, field, want, got);
            errors++;
        end
    endtask

    // request driver
    always @(posedge clk)
    begin
        flow_event_t ev;
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            in_gap = 0;
        end
        else
        begin
            if (in_valid && in_ready)
                predicted_status.push_back(detector_step(func_t'(func), active));
            if (!in_valid || in_ready)
            begin
                if (in_gap > 0)
                begin
                    in_gap--;
                    in_valid <= 1'b0;
                end
                else if (event_queue.size() > 0)
                begin
                    ev = event_queue.pop_front();
                    in_valid <= 1'b1;
                    func <= ev.kind;
                    active <= ev.act;
                    if ($urandom_range(0, 40) == 0)
                        in_burst = !in_burst;
                    in_gap = in_burst ? 0 : $urandom_range(0, 5);
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // result monitor
    always @(posedge clk)
    begin
        result_t seen;
        result_t want;
        if (!rst_n)
        begin
            out_ready <= 1'b0;
            out_stall = 0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                seen = {alarm, leak_status, notify_clear, notify_alert, total_pulse_count,
                        leak_pulse_count, leak_time_ms, pulse_interval_ms};
                if (predicted_status.size() == 0)
                begin
                    $display("%0t: unexpected result: expected none, actual %p", $time, seen);
                    errors++;
                end
                else
                begin
                    want = predicted_status.pop_front();
                    check_field("alarm", 32'(want.alarm), 32'(seen.alarm));
                    check_field("leak_status", 32'(want.leak_status), 32'(seen.leak_status));
                    check_field("notify_clear", 32'(want.notify_clear),
                                32'(seen.notify_clear));
                    check_field("notify_alert", 32'(want.notify_alert),
                                32'(seen.notify_alert));
                    check_field("total_pulse_count", want.total_pulse_count,
                                seen.total_pulse_count);
                    check_field("leak_pulse_count", want.leak_pulse_count,
                                seen.leak_pulse_count);
                    check_field("leak_time_ms", want.leak_time_ms, seen.leak_time_ms);
                    check_field("pulse_interval_ms", want.pulse_interval_ms,
                                seen.pulse_interval_ms);
                end
                if ($urandom_range(0, 40) == 0)
                    out_burst = !out_burst;
                out_stall = out_burst ? 0 : $urandom_range(0, 5);
            end
            if (out_stall > 0)
            begin
                out_stall--;
                out_ready <= 1'b0;
            end
            else
                out_ready <= 1'b1;
        end
    end

    // register shadow
    always @(posedge clk)
    begin
        if (rst_n && cfg_valid && cfg_ready)
        begin
            case (cfg_index_t'(cfg_index))
                CFG_WINDOW_MS:     det_cfg.window_ms = cfg_data;
                CFG_PULSE_THRESH:  det_cfg.pulse_threshold = cfg_data[15:0];
                CFG_CLEAR_WINDOWS: det_cfg.clear_windows = cfg_data[3:0];
                CFG_COOLDOWN_MS:   det_cfg.cooldown_ms = cfg_data;
                CFG_LF_MIN_IVL:    det_cfg.low_flow_min_interval = cfg_data;
                CFG_LF_MAX_IVL:    det_cfg.low_flow_max_interval = cfg_data;
                CFG_LF_HOLD_MS:    det_cfg.low_flow_hold_ms = cfg_data;
                CFG_CHECK_PERIOD:  det_cfg.check_period_ms = cfg_data[15:0];
                default:           ;
            endcase
        end
    end

    task automatic write_reg(input cfg_index_t idx, input logic [31:0] val);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    task automatic program_regs(input cfg_t s);
        write_reg(CFG_WINDOW_MS, s.window_ms);
        write_reg(CFG_PULSE_THRESH, 32'(s.pulse_threshold));
        write_reg(CFG_CLEAR_WINDOWS, 32'(s.clear_windows));
        write_reg(CFG_COOLDOWN_MS, s.cooldown_ms);
        write_reg(CFG_LF_MIN_IVL, s.low_flow_min_interval);
        write_reg(CFG_LF_MAX_IVL, s.low_flow_max_interval);
        write_reg(CFG_LF_HOLD_MS, s.low_flow_hold_ms);
        write_reg(CFG_CHECK_PERIOD, 32'(s.check_period_ms));
    endtask

    task automatic wait_idle();
        @(negedge clk);
        while (event_queue.size() != 0 || in_valid || predicted_status.size() != 0)
            @(negedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic add_event(input func_t kind, input logic act);
        flow_event_t ev;
        ev.kind = kind;
        ev.act = act;
        event_queue.push_back(ev);
        events_added++;
    endtask

    function automatic cfg_t random_setting();
        cfg_t s;
        s.window_ms = $urandom_range(1, 20);
        s.pulse_threshold = 16'($urandom_range(0, 4));
        s.clear_windows = 4'($urandom_range(0, 15));
        case ($urandom_range(0, 3))
            0:       s.cooldown_ms = 32'd0;
            1:       s.cooldown_ms = 32'hFFFF_FFFF;
            default: s.cooldown_ms = $urandom_range(1, 60);
        endcase
        s.low_flow_min_interval = $urandom_range(1, 6);
        s.low_flow_max_interval = s.low_flow_min_interval + $urandom_range(0, 8);
        s.low_flow_hold_ms = $urandom_range(0, 15);
        s.check_period_ms = 16'($urandom_range(1, 4));
        return s;
    endfunction

    task automatic add_traffic(input int count);
        int goal;
        int spacing;
        int reps;
        goal = events_added + count;
        while (events_added < goal)
        begin
            case ($urandom_range(0, 9))
                0, 1, 2, 3, 4:
                begin
                    // steady drip while quiet
                    spacing = $urandom_range(1, 10);
                    reps = $urandom_range(2, 10);
                    repeat (reps)
                    begin
                        repeat (spacing) add_event(FUNC_TICK, 1'($urandom_range(0, 1)));
                        add_event(FUNC_PULSE, 1'($urandom_range(0, 1)));
                        if ($urandom_range(0, 3) == 0)
                            add_event(FUNC_PULSE, 1'($urandom_range(0, 1)));
                    end
                end
                5, 6:
                begin
                    // water in use for a while
                    add_event(FUNC_USAGE, 1'b1);
                    repeat ($urandom_range(1, 12))
                        add_event($urandom_range(0, 1) ? FUNC_TICK : FUNC_PULSE,
                                  1'($urandom_range(0, 1)));
                    add_event(FUNC_USAGE, 1'b0);
                end
                7:
                    repeat ($urandom_range(3, 25))
                        add_event(FUNC_TICK, 1'($urandom_range(0, 1)));
                8:
                    add_event(FUNC_CLEAR, 1'($urandom_range(0, 1)));
                default:
                    repeat ($urandom_range(1, 6))
                        add_event(func_t'($urandom_range(0, 3)), 1'($urandom_range(0, 1)));
            endcase
        end
    endtask

    initial
    begin
        det = '0;
        det.last_alert_ms = ALERT_RESET;
        det_cfg = '{32'd60000, 16'd3, 4'd2, 32'd600000, 32'd341, 32'd10204, 32'd30000,
                    16'd1000};
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // defaults: first pulse at time zero, same-ms pulse, clear and usage
        add_event(FUNC_PULSE, 1'b1);
        add_event(FUNC_TICK, 1'b1);
        add_event(FUNC_PULSE, 1'b0);
        add_event(FUNC_PULSE, 1'b1);
        add_event(FUNC_CLEAR, 1'b1);
        add_event(FUNC_USAGE, 1'b1);
        add_event(FUNC_USAGE, 1'b0);
        wait_idle();

        // tight settings: leak, trickle, clear with zero clean windows, both notifications
        program_regs('{32'd3, 16'd1, 4'd0, 32'd0, 32'd1, 32'd4, 32'd2, 16'd1});
        add_event(FUNC_TICK, 1'b0);
        add_event(FUNC_PULSE, 1'b0);
        add_event(FUNC_PULSE, 1'b1);
        add_event(FUNC_PULSE, 1'b0);
        add_event(FUNC_TICK, 1'b0);
        add_event(FUNC_TICK, 1'b1);
        add_event(FUNC_TICK, 1'b0);
        add_event(FUNC_TICK, 1'b0);
        add_event(FUNC_TICK, 1'b0);
        add_event(FUNC_USAGE, 1'b1);
        add_event(FUNC_TICK, 1'b0);
        add_event(FUNC_PULSE, 1'b0);
        add_event(FUNC_USAGE, 1'b0);
        add_event(FUNC_CLEAR, 1'b0);
        add_event(FUNC_TICK, 1'b1);
        wait_idle();

        program_regs('{32'd1, 16'd0, 4'd1, 32'd0, 32'd1, 32'hFFFF_FFFF, 32'd0, 16'd1});
        add_traffic(150);
        wait_idle();

        program_regs('{32'hFFFF_FFFF, 16'hFFFF, 4'd15, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                       32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF});
        add_traffic(60);
        wait_idle();

        repeat (6)
        begin
            program_regs(random_setting());
            add_traffic(150);
            wait_idle();
        end

        program_regs('{32'd4, 16'd2, 4'd15, 32'hFFFF_FFFF, 32'd1, 32'd1, 32'd3, 16'd2});
        add_traffic(140);
        wait_idle();

        repeat (10) @(posedge clk);
        if (errors == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial
    begin
        #5000000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
